// ===== src/npcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcp_pkg
// Shared types, constants and helper functions of the nearest palette color
// and pack block.
// ----------------------------------------------------------------------------
package npcp_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int PAL_W           = 24;

  localparam logic [9:0] MAX_DIST     = 10'd765;
  localparam logic [7:0] ALPHA_THRESH = 8'd127;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic wr_en;
    logic load_query;
    logic rd_en;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    begin
      return (a > b) ? (a - b) : (b - a);
    end
  endfunction

  // floor(x / 255) for x below 65535 is (x + (x >> 8) + 1) >> 8.
  function automatic logic [4:0] scale5(input logic [7:0] v);
    logic [15:0] p;
    logic [15:0] t;
    begin
      p = ({8'b0, v} << 5) - {8'b0, v};
      t = p + (p >> 8) + 16'd1;
      return t[12:8];
    end
  endfunction

  function automatic logic [5:0] scale6(input logic [7:0] v);
    logic [15:0] p;
    logic [15:0] t;
    begin
      p = ({8'b0, v} << 6) - {8'b0, v};
      t = p + (p >> 8) + 16'd1;
      return t[13:8];
    end
  endfunction

endpackage

// ===== src/npcp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcp_in_if / npcp_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface npcp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (
    output valid, operation, entry_index, red, green, blue, alpha,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, red, green, blue, alpha,
    output ready
  );
endinterface

interface npcp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  palette_index;
  logic [15:0] color_argb1555;
  logic [15:0] color_rgb565;

  modport source (
    output valid, palette_index, color_argb1555, color_rgb565,
    input  ready
  );
  modport sink (
    input  valid, palette_index, color_argb1555, color_rgb565,
    output ready
  );
endinterface

// ===== src/npcp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/npcp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcp_ctrl
// Controller: accepts items, sequences the palette scan and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module npcp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  output npcp_pkg::ctrl_cmd_t cmd_o,
  input  npcp_pkg::dp_sts_t   sts_i
);
  import npcp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_CONVERT) begin
            cmd_o.load_query = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.rd_last) begin
          state_d = S_WAIT;
        end
      end
      // The last entry read is compared during this cycle.
      S_WAIT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/npcp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcp_dp
// Datapath: palette memory with valid bits, query registers, running
// minimum distance search and the output register.
// ----------------------------------------------------------------------------
module npcp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  npcp_pkg::in_item_t  item_i,
  input  npcp_pkg::ctrl_cmd_t cmd_i,
  output npcp_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          palette_index_o,
  output logic [15:0]         color_argb1555_o,
  output logic [15:0]         color_rgb565_o
);
  import npcp_pkg::*;

  logic [PALETTE_ENTRIES-1:0] ent_vld_q;
  logic                       wr_ok;
  logic [PAL_AW-1:0]          wr_addr;
  logic [PAL_W-1:0]           rdata;

  logic [PAL_AW-1:0] rd_addr_q;
  logic [PAL_AW-1:0] cmp_idx_q;
  logic              cmp_vld_q;
  logic              rd_vld_q;

  logic [7:0]  q_red_q, q_green_q, q_blue_q;
  logic [15:0] pk_argb_q, pk_rgb_q;
  logic [4:0]  s5_r, s5_g, s5_b;
  logic [5:0]  s6_g;

  logic [PAL_AW-1:0] best_idx_q;
  logic [9:0]        best_dist_q;

  logic [PAL_W-1:0] ent;
  logic [9:0]       cand_dist;
  logic             better;

  logic        out_valid_q;
  logic [7:0]  out_idx_q;
  logic [15:0] out_argb_q, out_rgb_q;

  assign wr_ok   = cmd_i.wr_en && ({1'b0, item_i.entry_index} < 9'(PALETTE_ENTRIES));
  assign wr_addr = item_i.entry_index[PAL_AW-1:0];

  npcp_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (wr_addr),
    .wdata_i ({item_i.red, item_i.green, item_i.blue}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  // An entry never written since reset reads as black.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      cmp_vld_q <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (wr_ok) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      cmp_vld_q <= cmd_i.rd_en;
      if (cmd_i.load_query) begin
        rd_addr_q <= '0;
      end else if (cmd_i.rd_en) begin
        rd_addr_q <= rd_addr_q + PAL_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_vld_q  <= ent_vld_q[rd_addr_q];
      cmp_idx_q <= rd_addr_q;
    end
  end

  assign s5_r = scale5(item_i.red);
  assign s5_g = scale5(item_i.green);
  assign s5_b = scale5(item_i.blue);
  assign s6_g = scale6(item_i.green);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      q_red_q   <= item_i.red;
      q_green_q <= item_i.green;
      q_blue_q  <= item_i.blue;
      pk_argb_q <= {(item_i.alpha > ALPHA_THRESH), s5_r, s5_g, s5_b};
      pk_rgb_q  <= {s5_r, s6_g, s5_b};
    end
  end

  assign ent       = rd_vld_q ? rdata : '0;
  assign cand_dist = {2'b0, abs_diff(ent[23:16], q_red_q)}
                   + {2'b0, abs_diff(ent[15:8], q_green_q)}
                   + {2'b0, abs_diff(ent[7:0], q_blue_q)};
  // Strict compare keeps the lowest index on a tie.
  assign better = cmp_vld_q && (cand_dist < best_dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q  <= '0;
      best_dist_q <= MAX_DIST;
    end else if (cmd_i.load_query) begin
      best_idx_q  <= '0;
      best_dist_q <= MAX_DIST;
    end else if (better) begin
      best_idx_q  <= cmp_idx_q;
      best_dist_q <= cand_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_idx_q  <= 8'(best_idx_q);
      out_argb_q <= pk_argb_q;
      out_rgb_q  <= pk_rgb_q;
    end
  end

  assign sts_o.rd_last   = (rd_addr_q == PAL_AW'(PALETTE_ENTRIES - 1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign palette_index_o  = out_idx_q;
  assign color_argb1555_o = out_argb_q;
  assign color_rgb565_o   = out_rgb_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("result register loaded while a result is still pending");

  a_dist_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load_query |=> best_dist_q <= $past(best_dist_q))
    else $error("best distance grew during a scan");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ok |=> ent_vld_q[$past(wr_addr)])
    else $error("palette write did not mark its entry valid");

  a_cmp_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |=> cmp_vld_q && (cmp_idx_q == $past(rd_addr_q)))
    else $error("compare stage index does not match the read address");

endmodule

// ===== src/nearest_palette_color_and_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_and_pack
// Palette lookup by smallest Manhattan RGB distance plus ARGB1555 and RGB565
// packing of the query color.
// ----------------------------------------------------------------------------
// Input items arrive on in_i (valid/ready). A write item stores its color in
// the palette entry named by entry_index and gives no result. A convert item
// starts a scan of the whole palette: one entry is read from the palette RAM
// and compared each cycle, and the result goes to the output register after
// the last entry is compared. The next item is taken only after that load,
// so a new convert is not taken while a scan is still running. The result
// carries the first index at minimum distance and both packed words.
// in_i.ready is high only while the controller is idle. A finished result
// sits in an output register; while the receiver stalls, write items and a
// new convert are still taken, and a new result waits until the register
// frees.
// Reset empties the output register and marks every palette entry as black
// through per-entry valid bits, so the block is ready in the first cycle.
// ----------------------------------------------------------------------------
module nearest_palette_color_and_pack (
  input  logic       clk_i,
  input  logic       rst_ni,
  npcp_in_if.sink    in_i,
  npcp_out_if.source out_o
);
  import npcp_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  in_item_t  item;

  assign item = '{
    operation:   in_i.operation,
    entry_index: in_i.entry_index,
    red:         in_i.red,
    green:       in_i.green,
    blue:        in_i.blue,
    alpha:       in_i.alpha
  };

  npcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  npcp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .palette_index_o  (out_o.palette_index),
    .color_argb1555_o (out_o.color_argb1555),
    .color_rgb565_o   (out_o.color_rgb565)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_palette_color_and_pack. A short table of
// directed items covers reset state, channel extremes, the alpha threshold,
// ties and the exact green scaling. Random palette writes and conversions
// follow. Every result is checked against a palette shadow and the packing
// arithmetic kept in the bench, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import npcp_pkg::*;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] argb1555;
    logic [15:0] rgb565;
  } pixel_result_t;

  typedef struct packed {
    in_item_t      item;
    logic          known;
    pixel_result_t result;
  } directed_row_t;

  localparam int NUM_DIRECTED     = 20;
  localparam int RANDOM_PER_PHASE = 435;
  localparam int DRAIN_CYCLES     = 300;

  // Rows with known set carry a result that can be read off directly; the
  // others are predicted from the palette shadow.
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{OP_CONVERT, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{8'd0, 16'h0000, 16'h0000}},
    '{'{OP_CONVERT, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 16'hFFFF, 16'hFFFF}},
    '{'{OP_CONVERT, 8'd0,   8'd255, 8'd255, 8'd255, 8'd127}, 1'b1, '{8'd0, 16'h7FFF, 16'hFFFF}},
    '{'{OP_CONVERT, 8'd0,   8'd0,   8'd0,   8'd0,   8'd128}, 1'b1, '{8'd0, 16'h8000, 16'h0000}},
    '{'{OP_CONVERT, 8'd0,   8'd0,   8'd85,  8'd0,   8'd0},   1'b1, '{8'd0, 16'h0140, 16'h02A0}},
    '{'{OP_CONVERT, 8'd0,   8'd0,   8'd170, 8'd0,   8'd0},   1'b1, '{8'd0, 16'h0280, 16'h0540}},
    '{'{OP_WRITE,   8'd255, 8'd255, 8'd255, 8'd255, 8'hAA},  1'b0, '0},
    '{'{OP_CONVERT, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0},   1'b0, '0},
    '{'{OP_WRITE,   8'd0,   8'd255, 8'd0,   8'd0,   8'h55},  1'b0, '0},
    '{'{OP_WRITE,   8'd1,   8'd100, 8'd100, 8'd100, 8'd0},   1'b0, '0},
    '{'{OP_WRITE,   8'd2,   8'd100, 8'd100, 8'd100, 8'd0},   1'b0, '0},
    '{'{OP_CONVERT, 8'd255, 8'd100, 8'd100, 8'd101, 8'd200}, 1'b0, '0},
    '{'{OP_CONVERT, 8'd0,   8'd200, 8'd10,  8'd10,  8'd0},   1'b0, '0},
    '{'{OP_WRITE,   8'd128, 8'd0,   8'd0,   8'd1,   8'd0},   1'b0, '0},
    '{'{OP_CONVERT, 8'd0,   8'd0,   8'd0,   8'd1,   8'd0},   1'b0, '0},
    '{'{OP_CONVERT, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{'{OP_CONVERT, 8'd0,   8'h0F,  8'hF0,  8'h5A,  8'hA5},  1'b0, '0},
    '{'{OP_WRITE,   8'd200, 8'd0,   8'd255, 8'd0,   8'd0},   1'b0, '0},
    '{'{OP_CONVERT, 8'd0,   8'd0,   8'd255, 8'd0,   8'hFF},  1'b0, '0},
    '{'{OP_CONVERT, 8'd0,   8'd255, 8'd255, 8'd0,   8'h80},  1'b0, '0}
  };

  logic clk;
  logic rst_n;

  npcp_in_if  in_ch ();
  npcp_out_if out_ch ();

  nearest_palette_color_and_pack i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  logic [23:0]   palette_shadow [PALETTE_ENTRIES];
  pixel_result_t pending_pixels [$];
  int            mismatch_count = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [4:0] scale_to_5(input logic [7:0] v);
    int unsigned prod;
    prod = {24'd0, v};
    prod = prod * 31 / 255;
    return prod[4:0];
  endfunction

  function automatic logic [5:0] scale_to_6(input logic [7:0] v);
    int unsigned prod;
    prod = {24'd0, v};
    prod = prod * 63 / 255;
    return prod[5:0];
  endfunction

  function automatic int unsigned channel_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? {24'd0, a - b} : {24'd0, b - a};
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic pixel_result_t predict_pixel(input in_item_t it);
    pixel_result_t res;
    int unsigned   best_dist;
    int unsigned   cand_dist;
    logic [23:0]   e;
    best_dist = 32'(MAX_DIST);
    res.index = 8'd0;
    // Strictly-smaller keeps the lowest index on ties.
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      e = palette_shadow[i];
      cand_dist = channel_gap(e[23:16], it.red) + channel_gap(e[15:8], it.green)
                + channel_gap(e[7:0], it.blue);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        res.index = i[7:0];
      end
    end
    res.argb1555 = {it.alpha > ALPHA_THRESH, scale_to_5(it.red), scale_to_5(it.green),
                    scale_to_5(it.blue)};
    res.rgb565   = {scale_to_5(it.red), scale_to_6(it.green), scale_to_5(it.blue)};
    return res;
  endfunction

  task automatic send_item(input in_item_t it, input logic known, input pixel_result_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= it.operation;
    in_ch.entry_index <= it.entry_index;
    in_ch.red         <= it.red;
    in_ch.green       <= it.green;
    in_ch.blue        <= it.blue;
    in_ch.alpha       <= it.alpha;
    do @(posedge clk); while (!in_ch.ready);
    if (it.operation == OP_CONVERT) begin
      pending_pixels.push_back(known ? typed : predict_pixel(it));
    end else if (int'(it.entry_index) < PALETTE_ENTRIES) begin
      palette_shadow[it.entry_index] = {it.red, it.green, it.blue};
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: palette_index %0d", out_ch.palette_index);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.palette_index !== want.index) begin
          $error("palette_index: expected %0d, got %0d", want.index, out_ch.palette_index);
          mismatch_count++;
        end
        if (out_ch.color_argb1555 !== want.argb1555) begin
          $error("color_argb1555: expected %h, got %h", want.argb1555, out_ch.color_argb1555);
          mismatch_count++;
        end
        if (out_ch.color_rgb565 !== want.rgb565) begin
          $error("color_rgb565: expected %h, got %h", want.rgb565, out_ch.color_rgb565);
          mismatch_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    in_item_t    it;
    logic [23:0] e;
    int          kind;
    int          spread;
    int          drain_wait;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    in_ch.alpha       = '0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) palette_shadow[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        it = '0;
        it.entry_index = 8'($urandom_range(255));
        it.alpha       = 8'($urandom_range(255));
        it.red         = 8'($urandom_range(255));
        it.green       = 8'($urandom_range(255));
        it.blue        = 8'($urandom_range(255));
        kind = $urandom_range(99);
        if (kind < 45) begin
          it.operation = OP_WRITE;
          if (kind < 4) it.entry_index = (kind < 2) ? 8'd0 : 8'd255;
          // Duplicate colors set up ties between entries.
          if ($urandom_range(9) == 0) begin
            e = palette_shadow[$urandom_range(PALETTE_ENTRIES - 1)];
            {it.red, it.green, it.blue} = e;
          end
        end else begin
          it.operation = OP_CONVERT;
          e = palette_shadow[$urandom_range(PALETTE_ENTRIES - 1)];
          if (kind < 60) begin
            {it.red, it.green, it.blue} = e;
          end else if (kind < 80) begin
            spread = $urandom_range(12);
            it.red   = clamp_byte(int'(e[23:16]) + $urandom_range(2 * spread) - spread);
            it.green = clamp_byte(int'(e[15:8]) + $urandom_range(2 * spread) - spread);
            it.blue  = clamp_byte(int'(e[7:0]) + $urandom_range(2 * spread) - spread);
          end else if (kind < 88) begin
            it.red   = $urandom_range(1) ? 8'd255 : 8'd0;
            it.green = $urandom_range(1) ? 8'd255 : 8'd0;
            it.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
          end
          if ($urandom_range(7) == 0) it.alpha = $urandom_range(1) ? 8'd128 : 8'd127;
        end
        send_item(it, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    drain_wait = DRAIN_CYCLES;
    repeat (drain_wait) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
